// ===== hdl/bsfc_pkg.sv =====
package bsfc_pkg;

  // serial multiplier operand and product widths
  localparam int MA_W = 34;
  localparam int MB_W = 17;
  localparam int P_W  = MA_W + MB_W - 1;

  localparam logic signed [16:0] PI_Q12     = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic signed [16:0] RADIUS_Q16 = 17'sd2621;

  localparam logic [2:0] REG_GAIN_TILT      = 3'd0;
  localparam logic [2:0] REG_GAIN_TILT_RATE = 3'd1;
  localparam logic [2:0] REG_GAIN_DISTANCE  = 3'd2;
  localparam logic [2:0] REG_GAIN_SPEED     = 3'd3;
  localparam logic [2:0] REG_TORQUE_LIMIT   = 3'd4;
  localparam logic [2:0] REG_TILT_LIMIT     = 3'd5;
  localparam logic [2:0] REG_SPEED_LIMIT    = 3'd6;
  localparam logic [2:0] REG_FILTER_ALPHA   = 3'd7;

  localparam logic [1:0] STATUS_RUN   = 2'd0;
  localparam logic [1:0] STATUS_LOST  = 2'd1;
  localparam logic [1:0] STATUS_ABORT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_WAIT,
    ST_FIN
  } st_t;

  typedef enum logic [2:0] {
    OP_FILT_L,
    OP_FILT_R,
    OP_DIST,
    OP_SPEED,
    OP_GAIN_TILT,
    OP_GAIN_RATE,
    OP_GAIN_DIST,
    OP_GAIN_SPEED
  } op_t;

endpackage

// ===== hdl/balance_state_feedback_controller_unit.sv =====
// an accepted in word runs prep, eight passes of the bit-serial multiplier and fin, where its out
// word is registered once the output slot is free; no new in word is taken until then
// (each pass: a load step, 17 bit steps and a done step)
// a dead wheel driver short-cuts the tick: prep goes straight to fin, with no multiplier passes
// the tare mean divider runs alongside the multiplier and does not hold up the tick
// rst_n is synchronous: registers return to their defaults, session restarts, no word held
module balance_state_feedback_controller_unit
  import bsfc_pkg::*;
#(
  parameter int TARE_SAMPLES = 200
)(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pitch, body rate, left_angle, right_angle, left_speed, right_speed,
  // imu_valid, left_driver_alive, right_driver_alive, zero pad
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // torque, status, tare_done, tilt, distance, speed, zero pad
  output logic [87:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [7:0] TARE_N = 8'(TARE_SAMPLES);

  function automatic logic signed [31:0] sat33(logic signed [32:0] x);
    if (x[32] != x[31]) return x[32] ? 32'sh80000000 : 32'sh7fffffff;
    return x[31:0];
  endfunction

  function automatic logic signed [15:0] sat18(logic signed [17:0] x);
    if (!(x[17:15] == 3'b000 || x[17:15] == 3'b111)) return x[17] ? 16'sh8000 : 16'sh7fff;
    return x[15:0];
  endfunction

  function automatic logic signed [15:0] sat17(logic signed [16:0] x);
    if (x[16] != x[15]) return x[16] ? 16'sh8000 : 16'sh7fff;
    return x[15:0];
  endfunction

  function automatic logic signed [31:0] sat37_32(logic signed [36:0] x);
    if (!(x[36:31] == '0 || x[36:31] == '1)) return x[36] ? 32'sh80000000 : 32'sh7fffffff;
    return x[31:0];
  endfunction

  function automatic logic signed [15:0] sat37_16(logic signed [36:0] x);
    if (!(x[36:15] == '0 || x[36:15] == '1)) return x[36] ? 16'sh8000 : 16'sh7fff;
    return x[15:0];
  endfunction

  function automatic logic signed [16:0] wrap_d(logic signed [15:0] now,
                                                logic signed [15:0] prev);
    logic signed [16:0] d;
    d = {now[15], now} - {prev[15], prev};
    if (d > PI_Q12) d = d - TWO_PI_Q12;
    else if (d < -PI_Q12) d = d + TWO_PI_Q12;
    return d;
  endfunction

  // configuration
  logic signed [15:0] gt_r, gr_r, gd_r, gs_r;
  logic [14:0]        tql_r, til_r, spl_r;
  logic [15:0]        alpha_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r    <= 16'sd2632;
      gr_r    <= 16'sd358;
      gd_r    <= -16'sd760;
      gs_r    <= -16'sd1521;
      tql_r   <= 15'd8192;
      til_r   <= 15'd2458;
      spl_r   <= 15'd7680;
      alpha_r <= 16'd7316;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_TILT:      gt_r    <= cfg_pwdata[15:0];
        REG_GAIN_TILT_RATE: gr_r    <= cfg_pwdata[15:0];
        REG_GAIN_DISTANCE:  gd_r    <= cfg_pwdata[15:0];
        REG_GAIN_SPEED:     gs_r    <= cfg_pwdata[15:0];
        REG_TORQUE_LIMIT:   tql_r   <= cfg_pwdata[14:0];
        REG_TILT_LIMIT:     til_r   <= cfg_pwdata[14:0];
        REG_SPEED_LIMIT:    spl_r   <= cfg_pwdata[14:0];
        REG_FILTER_ALPHA:   alpha_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_TILT:      cfg_prdata = {16'd0, gt_r};
      REG_GAIN_TILT_RATE: cfg_prdata = {16'd0, gr_r};
      REG_GAIN_DISTANCE:  cfg_prdata = {16'd0, gd_r};
      REG_GAIN_SPEED:     cfg_prdata = {16'd0, gs_r};
      REG_TORQUE_LIMIT:   cfg_prdata = {17'd0, tql_r};
      REG_TILT_LIMIT:     cfg_prdata = {17'd0, til_r};
      REG_SPEED_LIMIT:    cfg_prdata = {17'd0, spl_r};
      REG_FILTER_ALPHA:   cfg_prdata = {16'd0, alpha_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // sequencer
  st_t st_r, st_nxt;
  op_t op_r;
  logic mul_start;
  logic mul_done;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  mul_p;
  logic out_load;

  // captured word
  logic signed [15:0] pitch_r, rate_r, la_r, ra_r, ls_r, rs_r;
  logic               imu_r, alive_r;

  // controller state
  logic               sess_r, urdy_r;
  logic [7:0]         tcnt_r;
  logic signed [23:0] tsum_r;
  logic signed [15:0] offset_r;
  logic signed [15:0] lastl_r, lastr_r;
  logic signed [31:0] lu_r, ru_r;
  logic signed [15:0] fl_r, fr_r;

  logic               tare_done_r;
  logic signed [31:0] dist_r;
  logic signed [15:0] spd_r;
  logic signed [51:0] tacc_r;

  logic               out_valid_r;
  logic [87:0]        out_data_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_tvalid) st_nxt = ST_PREP;
      ST_PREP: st_nxt = alive_r ? ST_LOAD : ST_FIN;
      ST_LOAD: st_nxt = ST_WAIT;
      ST_WAIT: if (mul_done) st_nxt = (op_r == OP_GAIN_SPEED) ? ST_FIN : ST_LOAD;
      ST_FIN:  if (!out_valid_r || out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (st_r)
      ST_IDLE: in_tready = 1'b1;
      ST_LOAD: mul_start = 1'b1;
      ST_FIN:  out_load  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pitch_r <= in_tdata[15:0];
      rate_r  <= in_tdata[31:16];
      la_r    <= in_tdata[47:32];
      ra_r    <= in_tdata[63:48];
      ls_r    <= in_tdata[79:64];
      rs_r    <= in_tdata[95:80];
      imu_r   <= in_tdata[96];
      alive_r <= in_tdata[97] & in_tdata[98];
    end
  end

  // tick front end, evaluated in the prep cycle
  logic [7:0]         cnt0, cnt1;
  logic signed [23:0] sum0, sum1;
  logic               tare_run, ur, div_go;
  logic signed [31:0] base_l, base_r;
  logic signed [15:0] prev_l, prev_r;

  always_comb begin
    cnt0     = sess_r ? 8'd0 : tcnt_r;
    sum0     = sess_r ? 24'sd0 : tsum_r;
    tare_run = cnt0 < TARE_N;
    sum1     = tare_run ? sum0 + 24'(pitch_r) : sum0;
    cnt1     = tare_run ? cnt0 + 8'd1 : cnt0;
    div_go   = (st_r == ST_PREP) && alive_r && tare_run && (cnt1 == TARE_N);
    ur       = !sess_r && urdy_r;
    base_l   = ur ? lu_r : 32'sd0;
    base_r   = ur ? ru_r : 32'sd0;
    prev_l   = ur ? lastl_r : la_r;
    prev_r   = ur ? lastr_r : ra_r;
  end

  // tilt against the current upright offset
  logic signed [16:0] tilt_w;
  logic signed [15:0] tilt;
  logic signed [16:0] tilt_abs, absl, absr;
  logic               abort;

  always_comb begin
    tilt_w   = {pitch_r[15], pitch_r} - {offset_r[15], offset_r};
    tilt     = sat17(tilt_w);
    tilt_abs = tilt[15] ? -17'(tilt) : 17'(tilt);
    absl     = ls_r[15] ? -17'(ls_r) : 17'(ls_r);
    absr     = rs_r[15] ? -17'(rs_r) : 17'(rs_r);
    abort    = (tilt_abs > $signed({2'b00, til_r})) || !imu_r
               || (absl > $signed({2'b00, spl_r})) || (absr > $signed({2'b00, spl_r}));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_FILT_L: begin
        mul_a = MA_W'(ls_r) - MA_W'(fl_r);
        mul_b = {1'b0, alpha_r};
      end
      OP_FILT_R: begin
        mul_a = MA_W'(rs_r) - MA_W'(fr_r);
        mul_b = {1'b0, alpha_r};
      end
      OP_DIST: begin
        mul_a = MA_W'(lu_r) + MA_W'(ru_r);
        mul_b = RADIUS_Q16;
      end
      OP_SPEED: begin
        mul_a = MA_W'(fl_r) + MA_W'(fr_r);
        mul_b = RADIUS_Q16;
      end
      OP_GAIN_TILT: begin
        mul_a = MA_W'(tilt) <<< 4;
        mul_b = MB_W'(gt_r);
      end
      OP_GAIN_RATE: begin
        mul_a = MA_W'(rate_r) <<< 8;
        mul_b = MB_W'(gr_r);
      end
      OP_GAIN_DIST: begin
        mul_a = MA_W'(dist_r);
        mul_b = MB_W'(gd_r);
      end
      OP_GAIN_SPEED: begin
        mul_a = MA_W'(spd_r) <<< 4;
        mul_b = MB_W'(gs_r);
      end
      default: ;
    endcase
  end

  bsfc_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r <= 1'b1;
      urdy_r <= 1'b0;
      tcnt_r <= '0;
      tsum_r <= '0;
      lastl_r <= '0;
      lastr_r <= '0;
      lu_r <= '0;
      ru_r <= '0;
      fl_r <= '0;
      fr_r <= '0;
      op_r <= OP_FILT_L;
    end else begin
      case (st_r)
        ST_PREP: begin
          op_r <= OP_FILT_L;
          if (!alive_r) begin
            sess_r <= 1'b1;
            urdy_r <= 1'b0;
          end else begin
            sess_r  <= 1'b0;
            urdy_r  <= 1'b1;
            tcnt_r  <= cnt1;
            tsum_r  <= sum1;
            lu_r    <= sat33({base_l[31], base_l} + 33'(wrap_d(la_r, prev_l)));
            ru_r    <= sat33({base_r[31], base_r} + 33'(wrap_d(ra_r, prev_r)));
            lastl_r <= la_r;
            lastr_r <= ra_r;
            if (!ur) begin
              fl_r <= ls_r;
              fr_r <= rs_r;
            end
          end
        end
        ST_WAIT: begin
          if (mul_done) begin
            op_r <= op_t'(op_r + 3'd1);
            case (op_r)
              OP_FILT_L: fl_r <= sat18({{2{fl_r[15]}}, fl_r} + {mul_p[32], mul_p[32:16]});
              OP_FILT_R: fr_r <= sat18({{2{fr_r[15]}}, fr_r} + {mul_p[32], mul_p[32:16]});
              default: ;
            endcase
          end
        end
        ST_FIN: begin
          if (out_load && alive_r && abort) begin
            sess_r <= 1'b1;
            urdy_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_PREP) tare_done_r <= cnt1 >= TARE_N;
    if (st_r == ST_WAIT && mul_done) begin
      case (op_r)
        OP_DIST:       dist_r <= sat37_32(mul_p[P_W-1:13]);
        OP_SPEED:      spd_r  <= sat37_16(mul_p[P_W-1:13]);
        OP_GAIN_TILT:  tacc_r <= 52'(mul_p);
        OP_GAIN_RATE,
        OP_GAIN_DIST,
        OP_GAIN_SPEED: tacc_r <= tacc_r + 52'(mul_p);
        default: ;
      endcase
    end
  end

  // tare mean: restoring division of |sum| by the sample count, one bit a cycle
  logic               div_busy_r;
  logic [4:0]         div_cnt_r;
  logic [7:0]         div_rem_r;
  logic [23:0]        div_quo_r;
  logic               div_neg_r;
  logic [8:0]         div_t;
  logic               div_ge;
  logic [23:0]        div_q;

  assign div_t  = {div_rem_r, div_quo_r[23]};
  assign div_ge = div_t >= {1'b0, TARE_N};
  assign div_q  = {div_quo_r[22:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      offset_r   <= '0;
    end else if (div_go) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
      div_rem_r  <= '0;
      div_neg_r  <= sum1[23];
      div_quo_r  <= sum1[23] ? 24'(-sum1) : 24'(sum1);
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 5'd1;
      div_rem_r <= div_ge ? 8'(div_t - {1'b0, TARE_N}) : div_t[7:0];
      div_quo_r <= div_q;
      if (div_cnt_r == 5'd23) begin
        div_busy_r <= 1'b0;
        offset_r   <= div_neg_r ? -div_q[15:0] : div_q[15:0];
      end
    end
  end

  // torque: negate, drop 14 bits, clamp to the limit
  logic signed [51:0] tneg;
  logic signed [37:0] tsh;
  logic signed [37:0] tlim;
  logic signed [15:0] torque;

  always_comb begin
    tneg = -tacc_r;
    tsh  = tneg[51:14];
    tlim = {23'd0, tql_r};
    if (tsh > tlim)       torque = tlim[15:0];
    else if (tsh < -tlim) torque = 16'(-tlim);
    else                  torque = tsh[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (!alive_r) begin
        out_data_r <= {5'd0, 16'd0, 32'd0, 16'd0, 1'b0, STATUS_LOST, 16'd0};
      end else if (abort) begin
        out_data_r <= {5'd0, spd_r, dist_r, tilt, tare_done_r, STATUS_ABORT, 16'd0};
      end else begin
        out_data_r <= {5'd0, spd_r, dist_r, tilt, tare_done_r, STATUS_RUN, torque};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/bsfc_smul.sv =====
module bsfc_smul
  import bsfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic                   done,
  output logic signed [P_W-1:0]  p
);

  localparam int CNT_W = $clog2(MB_W);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [P_W-1:0]  mc_r;
  logic [MB_W-1:0]        mb_r;
  logic signed [P_W-1:0]  p_r;
  logic signed [P_W-1:0]  term;

  // one multiplier bit per cycle, the top bit carries negative weight
  assign term = mb_r[0] ? mc_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MB_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r <= P_W'(a);
      mb_r <= b;
      p_r  <= '0;
    end else if (busy_r) begin
      mc_r <= mc_r <<< 1;
      mb_r <= mb_r >> 1;
      if (cnt_r == CNT_W'(MB_W - 1)) begin
        p_r <= p_r - term;
      end else begin
        p_r <= p_r + term;
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// ===== sim/tb_balance_state_feedback_controller_unit.sv =====
`timescale 1ns / 100ps

module tb_balance_state_feedback_controller_unit
  import bsfc_pkg::*;
;

  localparam int TARE_N = 200;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [15:0] rate;
    logic signed [15:0] l_ang;
    logic signed [15:0] r_ang;
    logic signed [15:0] l_spd;
    logic signed [15:0] r_spd;
    bit imu_ok;
    bit l_alive;
    bit r_alive;
  } tick_in_t;

  typedef struct {
    logic signed [15:0] torque;
    logic [1:0]         status;
    bit                 tare_done;
    logic signed [15:0] tilt;
    logic signed [31:0] distance;
    logic signed [15:0] speed;
  } tick_out_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [87:0]  out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  balance_state_feedback_controller_unit dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // controller register shadows
  logic signed [15:0] k_tilt, k_rate, k_dist, k_speed;
  logic [14:0]        lim_torque, lim_tilt, lim_speed;
  logic [15:0]        alpha;

  // controller state shadows
  bit     new_session, angles_seeded;
  int     tare_cnt, tare_acc, upright;
  int     prev_l, prev_r, wheel_l, wheel_r, filt_l, filt_r;

  tick_out_t torque_q[$];
  int        errors;
  int        stall_left;
  bit        no_idle;
  int        l_walk, r_walk;

  tick_in_t  dir_in[$];
  bit        dir_typed[$];
  tick_out_t dir_exp[$];

  function automatic longint clampl(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic int unwrap_acc(int acc, int now, int last);
    longint d;
    d = longint'(now) - last;
    if (d > PI_Q12) d -= TWO_PI_Q12;
    if (d < -PI_Q12) d += TWO_PI_Q12;
    return int'(clampl(longint'(acc) + d, I32_MIN, I32_MAX));
  endfunction

  function automatic int lowpass(int f, int v);
    longint d;
    d = longint'(v) - f;
    return int'(clampl(longint'(f) + ((longint'(alpha) * d) >>> 16), -32768, 32767));
  endfunction

  task automatic run_tick(input tick_in_t t, output tick_out_t r);
    longint tilt, distance, spd, acc, al, ar, at;
    r = '{0, STATUS_RUN, 0, 0, 0, 0};
    if (!(t.l_alive && t.r_alive)) begin
      new_session = 1;
      angles_seeded = 0;
      r.status = STATUS_LOST;
      return;
    end
    if (new_session) begin
      new_session = 0;
      angles_seeded = 0;
      tare_cnt = 0;
      tare_acc = 0;
    end
    if (tare_cnt < TARE_N) begin
      tare_acc += int'(t.pitch);
      tare_cnt++;
      if (tare_cnt == TARE_N) upright = tare_acc / TARE_N;
    end
    tilt = clampl(longint'(t.pitch) - upright, -32768, 32767);
    if (!angles_seeded) begin
      prev_l = t.l_ang; prev_r = t.r_ang;
      wheel_l = 0; wheel_r = 0;
      filt_l = t.l_spd; filt_r = t.r_spd;
      angles_seeded = 1;
    end
    wheel_l = unwrap_acc(wheel_l, t.l_ang, prev_l);
    wheel_r = unwrap_acc(wheel_r, t.r_ang, prev_r);
    prev_l = t.l_ang; prev_r = t.r_ang;
    filt_l = lowpass(filt_l, t.l_spd);
    filt_r = lowpass(filt_r, t.r_spd);
    distance = clampl(((longint'(wheel_l) + wheel_r) * RADIUS_Q16) >>> 13, I32_MIN, I32_MAX);
    spd = clampl(((longint'(filt_l) + filt_r) * RADIUS_Q16) >>> 13, -32768, 32767);
    al = t.l_spd < 0 ? -longint'(t.l_spd) : longint'(t.l_spd);
    ar = t.r_spd < 0 ? -longint'(t.r_spd) : longint'(t.r_spd);
    at = tilt < 0 ? -tilt : tilt;
    if (at > lim_tilt || !t.imu_ok || (al > ar ? al : ar) > lim_speed) begin
      new_session = 1;
      angles_seeded = 0;
      r.status = STATUS_ABORT;
    end else begin
      acc = longint'(k_tilt) * tilt * 16 + longint'(k_rate) * longint'(t.rate) * 256
          + longint'(k_dist) * distance + longint'(k_speed) * spd * 16;
      r.torque = clampl((-acc) >>> 14, -longint'(lim_torque), longint'(lim_torque));
    end
    r.tare_done = tare_cnt >= TARE_N;
    r.tilt = tilt;
    r.distance = distance;
    r.speed = spd;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_GAIN_TILT:      k_tilt = val[15:0];
      REG_GAIN_TILT_RATE: k_rate = val[15:0];
      REG_GAIN_DISTANCE:  k_dist = val[15:0];
      REG_GAIN_SPEED:     k_speed = val[15:0];
      REG_TORQUE_LIMIT:   lim_torque = val[14:0];
      REG_TILT_LIMIT:     lim_tilt = val[14:0];
      REG_SPEED_LIMIT:    lim_speed = val[14:0];
      default:            alpha = val[15:0];
    endcase
  endtask

  task automatic load_gains(input int g0, g1, g2, g3, tl, tr, sl, fa);
    reg_write(REG_GAIN_TILT, g0);
    reg_write(REG_GAIN_TILT_RATE, g1);
    reg_write(REG_GAIN_DISTANCE, g2);
    reg_write(REG_GAIN_SPEED, g3);
    reg_write(REG_TORQUE_LIMIT, tl);
    reg_write(REG_TILT_LIMIT, tr);
    reg_write(REG_SPEED_LIMIT, sl);
    reg_write(REG_FILTER_ALPHA, fa);
  endtask

  // gap drawn first so valid only gets one update per step
  task automatic send_tick(input tick_in_t t, input bit typed, input tick_out_t want);
    int gap;
    tick_out_t r;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {5'd0, t.r_alive, t.l_alive, t.imu_ok, t.r_spd, t.l_spd,
                 t.r_ang, t.l_ang, t.rate, t.pitch};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    run_tick(t, r);
    torque_q.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    wait (torque_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic add_row(input int p, rt, la, ra, ls, rs, input bit imu, lv, rv,
                         input bit typed, input tick_out_t want);
    tick_in_t t;
    t = '{p, rt, la, ra, ls, rs, imu, lv, rv};
    dir_in.push_back(t);
    dir_typed.push_back(typed);
    dir_exp.push_back(want);
  endtask

  function automatic int wheel_walk(int a);
    a += $urandom_range(0, 1600) - 800;
    if (a > 12867) a -= 25736;
    if (a < -12868) a += 25736;
    return a;
  endfunction

  // clean ticks first so the tare can finish, then mixed with noise and lost drivers
  task automatic make_tick(input int i, output tick_in_t t);
    l_walk = wheel_walk(l_walk);
    r_walk = wheel_walk(r_walk);
    t = '{$urandom_range(0, 1200) - 600, $urandom_range(0, 65535), l_walk, r_walk,
          $urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000, 1, 1, 1};
    if (i >= 210) begin
      case ($urandom_range(0, 9))
        0, 1: t = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom};
        2: t.l_alive = 0;
        3: t.r_alive = 0;
        4: t.imu_ok = 0;
        5: t.pitch = $urandom;
        default: ;
      endcase
    end
  endtask

  task automatic chk(input string name, input longint e, input longint a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    tick_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (torque_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, out_tdata);
      end else begin
        e = torque_q.pop_front();
        chk("torque", e.torque, $signed(out_tdata[15:0]));
        chk("status", e.status, out_tdata[17:16]);
        chk("tare_done", e.tare_done, out_tdata[18]);
        chk("tilt", e.tilt, $signed(out_tdata[34:19]));
        chk("distance", e.distance, $signed(out_tdata[66:35]));
        chk("speed", e.speed, $signed(out_tdata[82:67]));
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 10);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    tick_in_t t;
    tick_out_t z;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    stall_left = 0;
    no_idle = 0;
    l_walk = 0;
    r_walk = 0;
    k_tilt = 2632; k_rate = 358; k_dist = -760; k_speed = -1521;
    lim_torque = 8192; lim_tilt = 2458; lim_speed = 7680; alpha = 7316;
    new_session = 1; angles_seeded = 0;
    tare_cnt = 0; tare_acc = 0; upright = 0;
    prev_l = 0; prev_r = 0; wheel_l = 0; wheel_r = 0; filt_l = 0; filt_r = 0;
    z = '{0, STATUS_RUN, 0, 0, 0, 0};

    // pitch, rate, l/r angle, l/r speed, imu, alive l/r, typed, expected
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 1, 1, '{0, STATUS_LOST, 0, 0, 0, 0});
    add_row(0, 0, 0, 0, 0, 0, 1, 1, 0, 1, '{0, STATUS_LOST, 0, 0, 0, 0});
    add_row(0, 0, 0, 0, 0, 0, 0, 1, 1, 1, '{0, STATUS_ABORT, 0, 0, 0, 0});
    add_row(32767, 0, 0, 0, 0, 0, 1, 1, 1, 1, '{0, STATUS_ABORT, 0, 32767, 0, 0});
    add_row(-32768, 0, 0, 0, 0, 0, 1, 1, 1, 1, '{0, STATUS_ABORT, 0, -32768, 0, 0});
    add_row(0, 0, 0, 0, 0, 0, 1, 1, 1, 1, '{0, STATUS_RUN, 0, 0, 0, 0});
    add_row(1000, 32767, 12000, -12000, 100, -100, 1, 1, 1, 0, z);
    add_row(-1000, -32768, -12000, 12000, 7680, -7680, 1, 1, 1, 0, z);
    add_row(2458, 0, 32767, -32768, 500, 500, 1, 1, 1, 0, z);
    add_row(2000, 100, -32768, 32767, -500, 3000, 1, 1, 1, 0, z);
    add_row(2459, 0, 0, 0, 0, 0, 1, 1, 1, 0, z);
    add_row(0, 0, 100, 200, 7681, 0, 1, 1, 1, 0, z);
    add_row(0, 0, 100, 200, 0, -32768, 1, 1, 1, 0, z);
    add_row(-2458, -5000, 300, -300, 32767, 0, 1, 1, 1, 0, z);
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 1, '{0, STATUS_LOST, 0, 0, 0, 0});

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_in.size(); i++)
      send_tick(dir_in[i], dir_typed[i], dir_exp[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_gains(2632, 358, -760, -1521, 8192, 2458, 7680, 7316);
        1: load_gains(32767, 32767, 32767, 32767, 32767, 32767, 32767, 65535);
        2: load_gains(-32768, -32768, -32768, -32768, 0, 32767, 32767, 0);
        3: load_gains($urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, $urandom);
        default: load_gains($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom_range(1000, 32767), $urandom_range(6000, 32767),
                            $urandom);
      endcase
      for (int i = 0; i < 250; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 4) == 0);
        make_tick(i, t);
        send_tick(t, 0, z);
      end
      no_idle = 0;
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bsfc_pkg.sv
hdl/bsfc_smul.sv
hdl/balance_state_feedback_controller_unit.sv
sim/tb_balance_state_feedback_controller_unit.sv
